/* sv/edge_normalized_2d_convolution_core_defines.svh */
// ----------------------------------------------------------------------------
// Edge-normalized convolution core assertion macros
// Shared shorthand for the concurrent checks of the convolution core.
// ----------------------------------------------------------------------------
`ifndef EDGE_NORMALIZED_2D_CONVOLUTION_CORE_DEFINES_SVH
`define EDGE_NORMALIZED_2D_CONVOLUTION_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define ENC_ASSERT_IMPLY(label, cond, expr) \
label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
	else $error("convolution core check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define ENC_ASSERT_NEXT(label, cond, expr) \
label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
	else $error("convolution core check failed");

`endif

/* sv/enc_pkg.sv */
// ----------------------------------------------------------------------------
// Convolution core package
// Shared constants, commands, register indexes and types.
// ----------------------------------------------------------------------------
package enc_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int DEF_KERNEL_MAX = 15;

	localparam int CFG_W = 11;

	localparam logic [1:0] CMD_TAP   = 2'd0;
	localparam logic [1:0] CMD_PIXEL = 2'd1;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_KSIZE  = 2'd2;

	localparam logic [10:0] RST_WIDTH  = 11'd200;
	localparam logic [10:0] RST_HEIGHT = 11'd200;
	localparam logic [3:0]  RST_KSIZE  = 4'd15;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_WALK,
		ST_DIV,
		ST_SEND
	} enc_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

/* sv/enc_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module enc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

/* sv/enc_window.sv */
// ----------------------------------------------------------------------------
// Convolution window walker
// Steps through the kernel taps one per cycle, reads tap and pixel, and
// accumulates the products of in-image taps with a shared multiplier.
// ----------------------------------------------------------------------------
module enc_window #(
	parameter int MAX_WIDTH  = enc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = enc_pkg::DEF_MAX_HEIGHT,
	parameter int KERNEL_MAX = enc_pkg::DEF_KERNEL_MAX,
	localparam int R    = KERNEL_MAX + 1,
	localparam int RSW  = $clog2(R),
	localparam int RAW  = $clog2(R * MAX_WIDTH),
	localparam int TAPS = KERNEL_MAX * KERNEL_MAX,
	localparam int TAW  = $clog2(TAPS),
	localparam int NW   = $clog2(TAPS + 1),
	localparam int XW   = $clog2(MAX_WIDTH + 1),
	localparam int YW   = $clog2(MAX_HEIGHT + 1),
	localparam int KW   = $clog2(KERNEL_MAX + 1),
	localparam int ACCW = TAW + 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [XW-1:0]          emit_x,
	input  logic [YW-1:0]          emit_y,
	input  logic [RSW-1:0]         emit_slot,
	input  logic [XW-1:0]          w,
	input  logic [YW-1:0]          h,
	input  logic [KW-1:0]          k,
	output logic [RAW-1:0]         row_addr,
	output logic [TAW-1:0]         tap_addr,
	input  logic [7:0]             pix_data,
	input  logic [15:0]            tap_data,
	output logic signed [ACCW-1:0] acc,
	output logic [NW-1:0]          count,
	output enc_pkg::unit_stat_t    stat
);

	localparam int SXW = XW + 1;
	localparam int SYW = YW + 1;

	logic                   walk_q;
	logic [KW-1:0]          i_q, j_q;
	logic [TAW-1:0]         tap_q;
	logic signed [SXW-1:0]  x_q, x0_q;
	logic signed [SYW-1:0]  y_q;
	logic [RSW-1:0]         slot_q;
	logic                   v_s1, last_s1, v_s2, last_s2, done_q;
	logic signed [24:0]     prod_s2;
	logic signed [ACCW-1:0] acc_q;
	logic [NW-1:0]          cnt_q;

	logic [KW-1:0]          half, km1;
	logic signed [SXW-1:0]  x0;
	logic signed [SYW-1:0]  y0;
	logic [RSW:0]           slot_sum;
	logic [RSW-1:0]         slot0, slot_next;
	logic                   in_range, last_tap;

	always_comb begin
		half      = k >> 1;
		km1       = k - KW'(1);
		x0        = $signed({1'b0, emit_x}) - $signed(SXW'(half));
		y0        = $signed({1'b0, emit_y}) - $signed(SYW'(half));
		slot_sum  = (RSW+1)'(emit_slot) + (RSW+1)'(R) - (RSW+1)'(half);
		slot0     = (slot_sum >= (RSW+1)'(R)) ? RSW'(slot_sum - (RSW+1)'(R))
		                                      : RSW'(slot_sum);
		slot_next = (slot_q == RSW'(R - 1)) ? '0 : slot_q + RSW'(1);
		in_range  = !x_q[SXW-1] && (x_q < $signed({1'b0, w})) &&
		            !y_q[SYW-1] && (y_q < $signed({1'b0, h}));
		last_tap  = (i_q == km1) && (j_q == km1);
		row_addr  = RAW'(slot_q) * RAW'(MAX_WIDTH) + RAW'(x_q[XW-1:0]);
		tap_addr  = tap_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q  <= 1'b0;
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			v_s2    <= 1'b0;
			last_s2 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			if (start) begin
				walk_q <= 1'b1;
			end else if (walk_q && last_tap) begin
				walk_q <= 1'b0;
			end
			v_s1    <= walk_q && in_range;
			last_s1 <= walk_q && last_tap;
			v_s2    <= v_s1;
			last_s2 <= last_s1;
			done_q  <= last_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			i_q    <= '0;
			j_q    <= '0;
			tap_q  <= '0;
			x_q    <= x0;
			x0_q   <= x0;
			y_q    <= y0;
			slot_q <= slot0;
		end else if (walk_q) begin
			tap_q <= tap_q + TAW'(1);
			if (j_q == km1) begin
				j_q    <= '0;
				i_q    <= i_q + KW'(1);
				x_q    <= x0_q;
				y_q    <= y_q + SYW'(1);
				slot_q <= slot_next;
			end else begin
				j_q <= j_q + KW'(1);
				x_q <= x_q + SXW'(1);
			end
		end
		prod_s2 <= $signed({1'b0, pix_data}) * $signed(tap_data);
		if (start) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACCW'(prod_s2);
			cnt_q <= cnt_q + NW'(1);
		end
	end

	assign acc       = acc_q;
	assign count     = cnt_q;
	assign stat.busy = walk_q || v_s1 || last_s1 || v_s2 || last_s2;
	assign stat.done = done_q;

endmodule

/* sv/enc_div.sv */
// ----------------------------------------------------------------------------
// Serial unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module enc_div #(
	parameter int MW = 32,
	parameter int NW = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [MW-1:0]       dividend,
	input  logic [NW-1:0]       divisor,
	output logic [MW-1:0]       quotient,
	output enc_pkg::unit_stat_t stat
);

	localparam int CW = $clog2(MW);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [MW-1:0] quo_q;
	logic [NW-1:0] rem_q;
	logic [NW-1:0] div_q;
	logic [NW:0]   trial;
	logic          fits;

	always_comb begin
		trial = {rem_q, quo_q[MW-1]};
		fits  = trial >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && cnt_q == '0) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
			cnt_q <= CW'(MW - 1);
		end else if (busy_q) begin
			rem_q <= fits ? NW'(trial - {1'b0, div_q}) : NW'(trial);
			quo_q <= {quo_q[MW-2:0], fits};
			cnt_q <= cnt_q - CW'(1);
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = busy_q && (cnt_q == '0);

endmodule

/* sv/edge_normalized_2d_convolution_core.sv */
// ----------------------------------------------------------------------------
// Edge-normalized 2-D convolution core
// Square-kernel convolution of a raster grey image, normalized by the number
// of kernel taps that fall inside the image.
// ----------------------------------------------------------------------------
// Usage: load the kernel taps (Q1.15) with tap commands, then stream the
// pixels of one frame in raster order, followed by drain commands until the
// result flagged last_of_frame has come out. Every pixel or drain transfer
// gives at most one result, in raster order, as soon as that output's window
// is complete. A tap load never stalls the input; a transfer that completes
// no window stalls it only while its readiness is checked. A transfer that
// completes a window holds the input while the shared multiply-accumulate
// walker steps through the kernel taps one per cycle and its pipeline
// registers drain, then while the serial divider yields one quotient bit
// per cycle, and until the output register is free to take the result.
// The row store is a single RAM of KERNEL_MAX+1 rows; it needs no clearing
// pass after reset, since a window only reads pixels of the current frame
// that are already stored. Configuration writes restart the frame.
// ----------------------------------------------------------------------------
`include "edge_normalized_2d_convolution_core_defines.svh"

module edge_normalized_2d_convolution_core #(
	parameter int MAX_WIDTH  = enc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = enc_pkg::DEF_MAX_HEIGHT,
	parameter int KERNEL_MAX = enc_pkg::DEF_KERNEL_MAX
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// input channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                command,
	input  logic [7:0]                tap_index,
	input  logic signed [15:0]        tap_value,
	input  logic [7:0]                pixel,
	// output channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [23:0]        filtered_value,
	output logic [9:0]                out_x,
	output logic [9:0]                out_y,
	output logic                      last_of_frame,
	// configuration
	input  logic                      cfg_write,
	input  logic [1:0]                cfg_index,
	input  logic [enc_pkg::CFG_W-1:0] cfg_data
);

	localparam int R    = KERNEL_MAX + 1;
	localparam int RSW  = $clog2(R);
	localparam int RAW  = $clog2(R * MAX_WIDTH);
	localparam int TAPS = KERNEL_MAX * KERNEL_MAX;
	localparam int TAW  = $clog2(TAPS);
	localparam int NW   = $clog2(TAPS + 1);
	localparam int XW   = $clog2(MAX_WIDTH + 1);
	localparam int YW   = $clog2(MAX_HEIGHT + 1);
	localparam int KW   = $clog2(KERNEL_MAX + 1);
	localparam int ACCW = TAW + 24;

	// Configuration registers, kept as written (kernel size: low four bits); the clamped values follow.
	logic [10:0] width_q, height_q;
	logic [3:0]  ksize_q;
	logic [XW-1:0] w;
	logic [YW-1:0] h;
	logic [KW-1:0] k;

	always_comb begin
		if (width_q == '0) begin
			w = XW'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w = XW'(MAX_WIDTH);
		end else begin
			w = XW'(width_q);
		end
		if (height_q == '0) begin
			h = YW'(1);
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			h = YW'(MAX_HEIGHT);
		end else begin
			h = YW'(height_q);
		end
		if (ksize_q == '0) begin
			k = KW'(1);
		end else if (32'(ksize_q) > 32'(KERNEL_MAX)) begin
			k = KW'(KERNEL_MAX);
		end else begin
			k = KW'(ksize_q);
		end
	end

	// Frame position: where the next pixel goes and which output is next.
	// The slot counters track the row modulo the number of stored rows.
	logic [XW-1:0]  in_col_q, emit_col_q;
	logic [YW-1:0]  in_row_q, emit_row_q;
	logic [RSW-1:0] in_slot_q, emit_slot_q;

	enc_pkg::enc_state_t state_q, state_d;
	enc_pkg::unit_stat_t win_stat, div_stat;

	logic in_xfer, out_free, pix_store, tap_store, cfg_hit;
	logic win_start, div_start, out_load;
	logic win_ready, last_pos;

	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid || !out_stall;
	assign pix_store = in_xfer && (command == enc_pkg::CMD_PIXEL) && (in_row_q < h);
	assign tap_store = in_xfer && (command == enc_pkg::CMD_TAP) &&
	                   (32'(tap_index) < 32'(TAPS));
	assign cfg_hit   = cfg_write && (cfg_index == enc_pkg::REG_WIDTH ||
	                   cfg_index == enc_pkg::REG_HEIGHT || cfg_index == enc_pkg::REG_KSIZE);

	// Readiness: the window's last in-image pixel must already be stored.
	logic [KW-1:0] half, rest;
	logic [YW:0]   cy_raw;
	logic [XW:0]   cx_raw;
	logic [YW-1:0] cy;
	logic [XW-1:0] cx;

	always_comb begin
		half   = k >> 1;
		rest   = k - KW'(1) - half;
		cy_raw = (YW+1)'(emit_row_q) + (YW+1)'(rest);
		cx_raw = (XW+1)'(emit_col_q) + (XW+1)'(rest);
		cy     = (cy_raw > (YW+1)'(h - YW'(1))) ? h - YW'(1) : YW'(cy_raw);
		cx     = (cx_raw > (XW+1)'(w - XW'(1))) ? w - XW'(1) : XW'(cx_raw);
		win_ready = (emit_row_q < h) && (emit_col_q < w) &&
		            ((in_row_q > cy) || ((in_row_q == cy) && (in_col_q > cx)));
		last_pos  = (emit_col_q == w - XW'(1)) && (emit_row_q == h - YW'(1));
	end

	// Sequencer: accept, check readiness, walk the taps, divide, hand over.
	always_comb begin
		state_d   = state_q;
		win_start = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			enc_pkg::ST_IDLE: begin
				if (in_xfer && command != enc_pkg::CMD_TAP) begin
					state_d = enc_pkg::ST_CHECK;
				end
			end
			enc_pkg::ST_CHECK: begin
				if (win_ready) begin
					win_start = 1'b1;
					state_d   = enc_pkg::ST_WALK;
				end else begin
					state_d = enc_pkg::ST_IDLE;
				end
			end
			enc_pkg::ST_WALK: begin
				if (win_stat.done) begin
					div_start = 1'b1;
					state_d   = enc_pkg::ST_DIV;
				end
			end
			enc_pkg::ST_DIV: begin
				if (div_stat.done) begin
					state_d = enc_pkg::ST_SEND;
				end
			end
			enc_pkg::ST_SEND: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = enc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = enc_pkg::ST_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != enc_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= enc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= enc_pkg::RST_WIDTH;
			height_q    <= enc_pkg::RST_HEIGHT;
			ksize_q     <= enc_pkg::RST_KSIZE;
			in_col_q    <= '0;
			in_row_q    <= '0;
			in_slot_q   <= '0;
			emit_col_q  <= '0;
			emit_row_q  <= '0;
			emit_slot_q <= '0;
		end else if (cfg_hit) begin
			// A register write restarts the frame.
			case (cfg_index)
				enc_pkg::REG_WIDTH:  width_q  <= cfg_data;
				enc_pkg::REG_HEIGHT: height_q <= cfg_data;
				enc_pkg::REG_KSIZE:  ksize_q  <= cfg_data[3:0];
				default: ;
			endcase
			in_col_q    <= '0;
			in_row_q    <= '0;
			in_slot_q   <= '0;
			emit_col_q  <= '0;
			emit_row_q  <= '0;
			emit_slot_q <= '0;
		end else begin
			if (pix_store) begin
				if (in_col_q + XW'(1) >= w) begin
					in_col_q  <= '0;
					in_row_q  <= in_row_q + YW'(1);
					in_slot_q <= (in_slot_q == RSW'(R - 1)) ? '0 : in_slot_q + RSW'(1);
				end else begin
					in_col_q <= in_col_q + XW'(1);
				end
			end
			if (out_load) begin
				if (last_pos) begin
					// Frame complete: all position counters start over.
					in_col_q    <= '0;
					in_row_q    <= '0;
					in_slot_q   <= '0;
					emit_col_q  <= '0;
					emit_row_q  <= '0;
					emit_slot_q <= '0;
				end else if (emit_col_q + XW'(1) >= w) begin
					emit_col_q  <= '0;
					emit_row_q  <= emit_row_q + YW'(1);
					emit_slot_q <= (emit_slot_q == RSW'(R - 1)) ? '0
					               : emit_slot_q + RSW'(1);
				end else begin
					emit_col_q <= emit_col_q + XW'(1);
				end
			end
		end
	end

	// Line store and kernel store.
	logic [RAW-1:0] row_rd_addr;
	logic [TAW-1:0] tap_rd_addr;
	logic [7:0]     pix_rd;
	logic [15:0]    tap_rd;

	enc_ram #(.WIDTH(8), .DEPTH(R * MAX_WIDTH)) u_row_ram (
		.clk     (clk),
		.wr_en   (pix_store),
		.wr_addr (RAW'(in_slot_q) * RAW'(MAX_WIDTH) + RAW'(in_col_q)),
		.wr_data (pixel),
		.rd_addr (row_rd_addr),
		.rd_data (pix_rd)
	);

	enc_ram #(.WIDTH(16), .DEPTH(TAPS)) u_tap_ram (
		.clk     (clk),
		.wr_en   (tap_store),
		.wr_addr (TAW'(tap_index)),
		.wr_data (tap_value),
		.rd_addr (tap_rd_addr),
		.rd_data (tap_rd)
	);

	// Shared multiply-accumulate over the window.
	logic signed [ACCW-1:0] acc;
	logic [NW-1:0]          tap_count;

	enc_window #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.KERNEL_MAX (KERNEL_MAX)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (win_start),
		.emit_x    (emit_col_q),
		.emit_y    (emit_row_q),
		.emit_slot (emit_slot_q),
		.w         (w),
		.h         (h),
		.k         (k),
		.row_addr  (row_rd_addr),
		.tap_addr  (tap_rd_addr),
		.pix_data  (pix_rd),
		.tap_data  (tap_rd),
		.acc       (acc),
		.count     (tap_count),
		.stat      (win_stat)
	);

	// Normalization: divide the magnitude, then restore the sign, which
	// truncates toward zero.
	logic            neg_q;
	logic [ACCW-1:0] mag, quo;
	logic [23:0]     q24;

	assign mag = acc[ACCW-1] ? ACCW'(-acc) : ACCW'(acc);

	enc_div #(.MW(ACCW), .NW(NW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag),
		.divisor  (tap_count),
		.quotient (quo),
		.stat     (div_stat)
	);

	assign q24 = quo[23:0];

	always_ff @(posedge clk) begin
		if (div_start) begin
			neg_q <= acc[ACCW-1];
		end
	end

	// Output register: the result waits here while the next transfer is taken.
	logic               out_valid_q, last_q;
	logic signed [23:0] fv_q;
	logic [9:0]         ox_q, oy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			fv_q   <= neg_q ? -$signed(q24) : $signed(q24);
			ox_q   <= 10'(emit_col_q);
			oy_q   <= 10'(emit_row_q);
			last_q <= last_pos;
		end
	end

	assign out_valid      = out_valid_q;
	assign filtered_value = fv_q;
	assign out_x          = ox_q;
	assign out_y          = oy_q;
	assign last_of_frame  = last_q;

	`ENC_ASSERT_IMPLY(a_walk_in_walk, win_stat.busy, state_q == enc_pkg::ST_WALK)
	`ENC_ASSERT_IMPLY(a_div_in_div, div_stat.busy, state_q == enc_pkg::ST_DIV)
	`ENC_ASSERT_IMPLY(a_frame_wrap, out_valid_q && last_q, emit_col_q == '0 && emit_row_q == '0)
	`ENC_ASSERT_NEXT(a_send_loads, out_load, out_valid_q && state_q == enc_pkg::ST_IDLE)

endmodule

/* tb/edge_normalized_2d_convolution_core_test.sv */
// ----------------------------------------------------------------------------
// Edge-normalized convolution core testbench
// Loads kernel taps, streams frames of pixels and drain ticks under several
// image and kernel sizes, and checks every output pixel against a predictor
// that keeps its own copy of the line store, kernel and frame counters.
// ----------------------------------------------------------------------------

// Scoreboard: predicts the output pixels from the accepted input transfers and
// compares them with the output transfers in order.
class conv_scoreboard;
	typedef struct {
		logic signed [23:0] value;
		logic [9:0]         x;
		logic [9:0]         y;
		logic               last;
	} pixel_out_t;

	localparam int ROWS = enc_pkg::DEF_KERNEL_MAX + 1;
	localparam int MAXW = enc_pkg::DEF_MAX_WIDTH;
	localparam int MAXH = enc_pkg::DEF_MAX_HEIGHT;
	localparam int KMAX = enc_pkg::DEF_KERNEL_MAX;
	localparam int TAPS = KMAX * KMAX;

	logic [7:0]  line_store [ROWS * MAXW];
	logic [15:0] coeffs [TAPS];
	int          wr_col, wr_row, rd_col, rd_row;
	logic [10:0] img_w, img_h;
	logic [3:0]  ksz;
	pixel_out_t  awaited [$];
	int          errors;

	function new();
		foreach (line_store[i]) line_store[i] = 8'd0;
		foreach (coeffs[i]) coeffs[i] = 16'd0;
		img_w = enc_pkg::RST_WIDTH;
		img_h = enc_pkg::RST_HEIGHT;
		ksz = enc_pkg::RST_KSIZE;
		restart();
		errors = 0;
	endfunction

	function void restart();
		wr_col = 0;
		wr_row = 0;
		rd_col = 0;
		rd_row = 0;
	endfunction

	function void write_reg(logic [1:0] idx, logic [10:0] data);
		if (idx == enc_pkg::REG_WIDTH) img_w = data;
		else if (idx == enc_pkg::REG_HEIGHT) img_h = data;
		else if (idx == enc_pkg::REG_KSIZE) ksz = data[3:0];
		else return;
		restart();
	endfunction

	function int clamp(int v, int lo, int hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// Notes one accepted input transfer and queues the output it completes.
	function void note_transfer(logic [1:0] cmd, logic [7:0] tidx, logic [15:0] tval,
			logic [7:0] pix);
		int w, h, k, half, rest, cx, cy, n, yy, xx;
		longint acc, q;
		pixel_out_t r;
		w = clamp(int'(img_w), 1, MAXW);
		h = clamp(int'(img_h), 1, MAXH);
		k = clamp(int'(ksz), 1, KMAX);
		if (cmd == enc_pkg::CMD_TAP) begin
			if (tidx < TAPS) coeffs[tidx] = tval;
			return;
		end
		if (cmd == enc_pkg::CMD_PIXEL && wr_row < h) begin
			line_store[(wr_row % ROWS) * MAXW + (wr_col % MAXW)] = pix;
			wr_col++;
			if (wr_col >= w) begin
				wr_col = 0;
				wr_row++;
			end
		end
		if (rd_row >= h || rd_col >= w) return;
		// The output waits until the last in-image pixel of its window is in.
		half = k / 2;
		rest = k - 1 - half;
		cy = clamp(rd_row + rest, 0, h - 1);
		cx = clamp(rd_col + rest, 0, w - 1);
		if (!(wr_row > cy || (wr_row == cy && wr_col > cx))) return;
		acc = 0;
		n = 0;
		for (int i = 0; i < k; i++) begin
			yy = rd_row + i - half;
			if (yy < 0 || yy >= h) continue;
			for (int j = 0; j < k; j++) begin
				xx = rd_col + j - half;
				if (xx < 0 || xx >= w) continue;
				acc += longint'($signed(coeffs[i * k + j])) *
					longint'(line_store[(yy % ROWS) * MAXW + (xx % MAXW)]);
				n++;
			end
		end
		q = acc / n;
		r.value = q[23:0];
		r.x = rd_col[9:0];
		r.y = rd_row[9:0];
		r.last = (rd_col == w - 1) && (rd_row == h - 1);
		awaited.push_back(r);
		if (r.last) begin
			restart();
		end else begin
			rd_col++;
			if (rd_col >= w) begin
				rd_col = 0;
				rd_row++;
			end
		end
	endfunction

	function void check_result(logic signed [23:0] value, logic [9:0] x, logic [9:0] y,
			logic last);
		pixel_out_t e;
		if (awaited.size() == 0) begin
			$display("%0t: unexpected output pixel value %0d at (%0d,%0d)",
				$time, value, x, y);
			errors++;
			return;
		end
		e = awaited.pop_front();
		if (value !== e.value) begin
			$display("%0t: filtered_value expected %0d actual %0d", $time, e.value, value);
			errors++;
		end
		if (x !== e.x) begin
			$display("%0t: out_x expected %0d actual %0d", $time, e.x, x);
			errors++;
		end
		if (y !== e.y) begin
			$display("%0t: out_y expected %0d actual %0d", $time, e.y, y);
			errors++;
		end
		if (last !== e.last) begin
			$display("%0t: last_of_frame expected %0d actual %0d", $time, e.last, last);
			errors++;
		end
	endfunction
endclass

module edge_normalized_2d_convolution_core_test;

	localparam int CYCLE_LIMIT = 4000000;
	localparam int SETTLE = 300;
	localparam int PHASES = 15;
	localparam int ITEMS_PER_PHASE = 72;
	localparam int CFG_W = enc_pkg::CFG_W;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         command = enc_pkg::CMD_TAP;
	logic [7:0]         tap_index = 8'd0;
	logic signed [15:0] tap_value = 16'sd0;
	logic [7:0]         pixel = 8'd0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [23:0] filtered_value;
	logic [9:0]         out_x;
	logic [9:0]         out_y;
	logic               last_of_frame;
	logic               cfg_write = 1'b0;
	logic [1:0]         cfg_index = enc_pkg::REG_WIDTH;
	logic [CFG_W-1:0]   cfg_data = '0;

	// Drain command; any code above the pixel command drains as well.
	localparam logic [1:0] CMD_DRAIN = 2'd2;
	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam logic [1:0] REG_NONE  = 2'd3;

	conv_scoreboard sb = new();
	int cycles = 0;
	// When set, neither side inserts random idle cycles.
	bit quiet = 1'b0;
	// Cycles the receiver still has to hold off in one stretch.
	int hold_cycles = 0;

	edge_normalized_2d_convolution_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .command(command),
		.tap_index(tap_index), .tap_value(tap_value), .pixel(pixel),
		.out_valid(out_valid), .out_stall(out_stall), .filtered_value(filtered_value),
		.out_x(out_x), .out_y(out_y), .last_of_frame(last_of_frame),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Receiver: every output transfer is checked, then the stall for the next
	// cycle is chosen. A requested hold-off overrides the random stall.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(filtered_value, out_x, out_y, last_of_frame);
		if (hold_cycles > 0) begin
			hold_cycles--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !quiet && ($urandom_range(0, 99) < 12);
		end
	end

	// Offers one input transfer and holds it until accepted. Valid stays high
	// into the next transfer unless an idle gap is drawn.
	task automatic send(logic [1:0] cmd, logic [7:0] tidx, logic [15:0] tval, logic [7:0] pix);
		if (!quiet && $urandom_range(0, 99) < 12) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		tap_index <= tidx;
		tap_value <= tval;
		pixel <= pix;
		do @(posedge clk); while (in_stall);
		sb.note_transfer(cmd, tidx, tval, pix);
	endtask

	// Drops valid and waits until every predicted output has come out, then
	// lets the core finish any transfer that completes no window.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_geometry(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h,
			logic [CFG_W-1:0] k);
		write_reg(enc_pkg::REG_WIDTH, w);
		write_reg(enc_pkg::REG_HEIGHT, h);
		write_reg(enc_pkg::REG_KSIZE, k);
		// An index past the last register must be ignored.
		write_reg(REG_NONE, CFG_W'($urandom));
	endtask

	// One random input transfer. Pixels dominate so that frames complete;
	// the rest are tap reloads, drains and the spare drain code.
	task automatic random_transfer();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 6)
			send(enc_pkg::CMD_TAP, 8'($urandom_range(0, 255)), 16'($urandom), 8'($urandom));
		else if (pick < 78)
			send(enc_pkg::CMD_PIXEL, 8'($urandom), 16'($urandom), 8'($urandom));
		else if (pick < 94)
			send(CMD_DRAIN, 8'($urandom), 16'($urandom), 8'($urandom));
		else
			send(CMD_SPARE, 8'($urandom), 16'($urandom), 8'($urandom));
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the whole kernel store first so no window reads a stale tap.
		for (int t = 0; t < 225; t++)
			send(enc_pkg::CMD_TAP, 8'(t), 16'($urandom), 8'($urandom));

		// Directed: a 3x2 frame with a 3x3 kernel of extreme taps, extreme
		// pixels, an out-of-range tap index, the spare drain code and plain drains.
		settle();
		set_geometry(11'd3, 11'd2, 11'd3);
		for (int t = 0; t < 9; t++)
			send(enc_pkg::CMD_TAP, 8'(t), (t % 2) ? 16'h8000 : 16'h7FFF, 8'd0);
		send(enc_pkg::CMD_TAP, 8'd255, 16'h1234, 8'd0);
		send(enc_pkg::CMD_PIXEL, 8'd0, 16'd0, 8'd255);
		send(enc_pkg::CMD_PIXEL, 8'd0, 16'd0, 8'd0);
		send(enc_pkg::CMD_PIXEL, 8'd0, 16'd0, 8'd255);
		send(enc_pkg::CMD_PIXEL, 8'd0, 16'd0, 8'd255);
		send(enc_pkg::CMD_PIXEL, 8'd0, 16'd0, 8'd255);
		send(enc_pkg::CMD_PIXEL, 8'd0, 16'd0, 8'd255);
		send(CMD_SPARE, 8'd0, 16'd0, 8'd0);
		send(CMD_DRAIN, 8'd0, 16'd0, 8'd0);
		send(CMD_DRAIN, 8'd0, 16'd0, 8'd0);
		send(CMD_DRAIN, 8'd0, 16'd0, 8'd0);
		send(CMD_DRAIN, 8'd0, 16'd0, 8'd0);
		settle();

		// Random phases. The first three hit the register extremes, including
		// zero and oversized values that the core clamps; the rest use small
		// frames so that most windows complete quickly.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: set_geometry(11'h7FF, 11'd0, 11'h7F0);
				1: set_geometry(11'd1, 11'd1024, 11'd15);
				2: set_geometry(11'd1024, 11'd16, 11'd1);
				default: set_geometry(CFG_W'($urandom_range(0, 10)),
					CFG_W'($urandom_range(0, 10)),
					{7'($urandom), 4'($urandom_range(0, 15))});
			endcase
			quiet = (p == 6);
			// A long receiver hold-off while the sender keeps offering.
			if (p == 8) hold_cycles = 3000;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) random_transfer();
			settle();
		end
		quiet = 1'b0;

		if (sb.awaited.size() != 0) sb.errors++;
		if (sb.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
